### hdl/pnsa_pkg.sv
package pnsa_pkg;

    localparam int SRC_ROWS = 1024;
    localparam int SRC_COLS = 1024;
    localparam int MAX_LIM  = (SRC_ROWS > SRC_COLS) ? SRC_ROWS : SRC_COLS;

    // Quotient bits resolved by the divider chain; one cell per bit.
    localparam int QB = $clog2(MAX_LIM + 1);

    // Remainder and divisor width through the divider chain.
    localparam int RW = 101;

    localparam int CW   = 48;
    localparam int NREG = 8;
    localparam int IW   = 4;

    localparam logic [IW-1:0] REG_ROW_X   = 4'd0;
    localparam logic [IW-1:0] REG_ROW_Y   = 4'd1;
    localparam logic [IW-1:0] REG_ROW_OFF = 4'd2;
    localparam logic [IW-1:0] REG_COL_X   = 4'd3;
    localparam logic [IW-1:0] REG_COL_Y   = 4'd4;
    localparam logic [IW-1:0] REG_COL_OFF = 4'd5;
    localparam logic [IW-1:0] REG_DEN_X   = 4'd6;
    localparam logic [IW-1:0] REG_DEN_Y   = 4'd7;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } t_in;

    typedef struct packed {
        logic [9:0]  src_row;
        logic [9:0]  src_col;
        logic [19:0] src_address;
        logic        inside_res;
    } t_out;

    typedef logic [NREG-1:0][CW-1:0] t_coef;

    // Beat travelling along the divider chain.
    typedef struct packed {
        logic          valid;
        logic          dz;
        logic          neg_r;
        logic          neg_c;
        logic          over_r;
        logic          over_c;
        logic [RW-1:0] d;
        logic [RW-1:0] rr;
        logic [RW-1:0] rc;
        logic [QB-1:0] qr;
        logic [QB-1:0] qc;
    } t_div;

endpackage

### hdl/projective_nearest_source_address.sv
// Pipeline: six arithmetic stages, one divider cell per quotient bit and an output stage
// lie between start and o_valid.
// Throughput: one item per clock; busy stays low and the result strobe cannot be held off.
// Reset (synchronous, active low) clears the pipeline valids and all coefficients to zero.
module projective_nearest_source_address import pnsa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_in           i_item,
    output logic          o_valid,
    output t_out          o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [IW-1:0] i_cfg_index,
    input  logic [CW-1:0] i_cfg_data
);

    t_coef r_coef;
    t_div  chain [QB+1];
    t_out  r_res;
    logic  r_valid;

    logic ok_r, ok_c, in_image;
    logic [QB+16:0] addr_full;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid && i_cfg_index < IW'(NREG)) begin
            r_coef[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    pnsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !busy),
        .i_item  (i_item),
        .i_coef  (r_coef),
        .o_div   (chain[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_cell
        pnsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (chain[k]),
            .o_div   (chain[k+1])
        );
    end

    // A zero quotient counts as inside whatever its sign.
    always_comb begin
        ok_r = (chain[QB].qr == '0)
            || (!chain[QB].neg_r && !chain[QB].over_r
                && {1'b0, chain[QB].qr} < (QB+1)'(SRC_ROWS));
        ok_c = (chain[QB].qc == '0)
            || (!chain[QB].neg_c && !chain[QB].over_c
                && {1'b0, chain[QB].qc} < (QB+1)'(SRC_COLS));
        in_image  = !chain[QB].dz && ok_r && ok_c;
        addr_full = (QB+17)'(chain[QB].qr) * (QB+17)'(SRC_COLS) + (QB+17)'(chain[QB].qc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain[QB].valid;
        end
        r_res.src_row     <= in_image ? 10'(chain[QB].qr) : '0;
        r_res.src_col     <= in_image ? 10'(chain[QB].qc) : '0;
        r_res.src_address <= in_image ? addr_full[19:0] : '0;
        r_res.inside_res  <= in_image;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

### hdl/pnsa_front.sv
module pnsa_front import pnsa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_in   i_item,
    input  t_coef i_coef,
    output t_div  o_div
);

    logic [4:0] r_v;

    logic signed [56:0] r_lo [6];
    logic signed [55:0] r_hi [6];
    logic signed [56:0] n_lo [6];
    logic signed [55:0] n_hi [6];
    logic signed [79:0] r_p  [6];
    logic signed [79:0] n_p  [6];

    logic signed [82:0] r_den, r_nr, r_nc;
    logic signed [82:0] n_den, n_nr, n_nc;
    logic signed [RW-1:0] r_mr, r_mc, r_d2;
    logic r_dz4;
    logic [RW-1:0] r_ar, r_ac, r_b;
    logic r_neg_r, r_neg_c, r_dz5;
    t_div r_out;

    localparam logic signed [82:0] DEN_ONE = {34'd0, 1'b1, 48'd0};

    // Coefficient order: row x, row y, col x, col y, den x, den y.
    logic [CW-1:0] sel_coef [6];
    assign sel_coef[0] = i_coef[REG_ROW_X];
    assign sel_coef[1] = i_coef[REG_ROW_Y];
    assign sel_coef[2] = i_coef[REG_COL_X];
    assign sel_coef[3] = i_coef[REG_COL_Y];
    assign sel_coef[4] = i_coef[REG_DEN_X];
    assign sel_coef[5] = i_coef[REG_DEN_Y];

    // Each 48 by 32 product is split into two 24-bit halves.
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            if (j % 2 == 0) begin
                n_lo[j] = $signed({1'b0, sel_coef[j][23:0]}) * $signed(i_item.world_x);
                n_hi[j] = $signed(sel_coef[j][47:24]) * $signed(i_item.world_x);
            end else begin
                n_lo[j] = $signed({1'b0, sel_coef[j][23:0]}) * $signed(i_item.world_y);
                n_hi[j] = $signed(sel_coef[j][47:24]) * $signed(i_item.world_y);
            end
            n_p[j] = (80'(r_hi[j]) <<< 24) + 80'(r_lo[j]);
        end
        n_den = 83'(r_p[4]) + 83'(r_p[5]) + DEN_ONE;
        n_nr  = 83'(r_p[0]) + 83'(r_p[1])
              + (83'($signed(i_coef[REG_ROW_OFF])) <<< 8);
        n_nc  = 83'(r_p[2]) + 83'(r_p[3])
              + (83'($signed(i_coef[REG_COL_OFF])) <<< 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out.valid <= 1'b0;
        end else begin
            r_v         <= {r_v[3:0], i_take};
            r_out.valid <= r_v[4];
        end
        for (int j = 0; j < 6; j++) begin
            r_lo[j] <= n_lo[j];
            r_hi[j] <= n_hi[j];
            r_p[j]  <= n_p[j];
        end
        r_den <= n_den;
        r_nr  <= n_nr;
        r_nc  <= n_nc;

        // Quotient plus one half is (N * 2^17 + D) / (2 * D).
        r_mr  <= (RW'(r_nr) <<< 17) + RW'(r_den);
        r_mc  <= (RW'(r_nc) <<< 17) + RW'(r_den);
        r_d2  <= RW'(r_den) <<< 1;
        r_dz4 <= (r_den == '0);

        r_ar    <= r_mr[RW-1] ? RW'(-r_mr) : RW'(r_mr);
        r_ac    <= r_mc[RW-1] ? RW'(-r_mc) : RW'(r_mc);
        r_b     <= r_d2[RW-1] ? RW'(-r_d2) : RW'(r_d2);
        r_neg_r <= r_mr[RW-1] ^ r_d2[RW-1];
        r_neg_c <= r_mc[RW-1] ^ r_d2[RW-1];
        r_dz5   <= r_dz4;

        r_out.dz     <= r_dz5;
        r_out.neg_r  <= r_neg_r;
        r_out.neg_c  <= r_neg_c;
        r_out.over_r <= r_ar >= (r_b << QB);
        r_out.over_c <= r_ac >= (r_b << QB);
        r_out.d      <= r_b << (QB - 1);
        r_out.rr     <= r_ar;
        r_out.rc     <= r_ac;
        r_out.qr     <= '0;
        r_out.qc     <= '0;
    end

    assign o_div = r_out;

endmodule

### hdl/pnsa_cell.sv
module pnsa_cell import pnsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_div i_div,
    output t_div o_div
);

    t_div r_div;
    logic ge_r, ge_c;

    assign ge_r = i_div.rr >= i_div.d;
    assign ge_c = i_div.rc >= i_div.d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else begin
            r_div.valid <= i_div.valid;
        end
        r_div.dz     <= i_div.dz;
        r_div.neg_r  <= i_div.neg_r;
        r_div.neg_c  <= i_div.neg_c;
        r_div.over_r <= i_div.over_r;
        r_div.over_c <= i_div.over_c;
        r_div.d      <= i_div.d >> 1;
        r_div.rr     <= ge_r ? i_div.rr - i_div.d : i_div.rr;
        r_div.rc     <= ge_c ? i_div.rc - i_div.d : i_div.rc;
        r_div.qr     <= {i_div.qr[QB-2:0], ge_r};
        r_div.qc     <= {i_div.qc[QB-2:0], ge_c};
    end

    assign o_div = r_div;

endmodule

### tb/pnsa_checker.sv
`timescale 1ns / 100ps

module pnsa_checker import pnsa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  t_in           i_item,
    input  logic          i_valid,
    input  t_out          i_result,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [IW-1:0] i_cfg_index,
    input  logic [CW-1:0] i_cfg_data,
    output int            o_fails,
    output int            o_pending
);

    logic [CW-1:0] coef_shadow [NREG];
    t_out          expected_lookups [$];

    // Nearest source index along one axis; returns 0 when it falls outside [0, limit).
    function automatic bit axis_round(input logic signed [127:0] num,
                                      input logic signed [127:0] den,
                                      input int limit, output logic [31:0] idx);
        logic signed [127:0] m;
        logic signed [127:0] d2;
        logic [127:0]        um;
        logic [127:0]        ud;
        logic [127:0]        q;
        m  = (num <<< 17) + den;
        d2 = den <<< 1;
        um = m[127] ? -m : m;
        ud = d2[127] ? -d2 : d2;
        q  = um / ud;
        idx = 0;
        if (q == 0)
            return 1'b1;
        if ((m[127] != d2[127]) || q >= limit)
            return 1'b0;
        idx = q[31:0];
        return 1'b1;
    endfunction

    function automatic t_out source_lookup(input t_in it);
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] den;
        logic signed [127:0] nrow;
        logic signed [127:0] ncol;
        logic [31:0]         row;
        logic [31:0]         col;
        bit                  ok;
        t_out                r;
        x    = it.world_x;
        y    = it.world_y;
        den  = $signed(coef_shadow[REG_DEN_X]) * x + $signed(coef_shadow[REG_DEN_Y]) * y
               + (128'sd1 <<< 48);
        nrow = $signed(coef_shadow[REG_ROW_X]) * x + $signed(coef_shadow[REG_ROW_Y]) * y
               + ($signed(coef_shadow[REG_ROW_OFF]) <<< 8);
        ncol = $signed(coef_shadow[REG_COL_X]) * x + $signed(coef_shadow[REG_COL_Y]) * y
               + ($signed(coef_shadow[REG_COL_OFF]) <<< 8);
        r   = '0;
        row = 0;
        col = 0;
        ok  = (den != 0);
        if (ok)
            ok = axis_round(nrow, den, SRC_ROWS, row);
        if (ok)
            ok = axis_round(ncol, den, SRC_COLS, col);
        if (ok) begin
            r.src_row     = row[9:0];
            r.src_col     = col[9:0];
            r.src_address = 20'(row * SRC_COLS + col);
            r.inside_res  = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fails++;
    endtask

    initial begin
        o_fails = 0;
        foreach (coef_shadow[k])
            coef_shadow[k] = '0;
    end

    assign o_pending = expected_lookups.size();

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (coef_shadow[k])
                coef_shadow[k] = '0;
        end else begin
            if (i_start && !i_busy)
                expected_lookups.push_back(source_lookup(i_item));
            if (i_valid) begin
                if (expected_lookups.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding", $time);
                    o_fails++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_result.src_row !== want.src_row)
                        report_mismatch("src_row", 32'(i_result.src_row),
                                        32'(want.src_row));
                    if (i_result.src_col !== want.src_col)
                        report_mismatch("src_col", 32'(i_result.src_col),
                                        32'(want.src_col));
                    if (i_result.src_address !== want.src_address)
                        report_mismatch("src_address", 32'(i_result.src_address),
                                        32'(want.src_address));
                    if (i_result.inside_res !== want.inside_res)
                        report_mismatch("inside_res", 32'(i_result.inside_res),
                                        32'(want.inside_res));
                end
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NREG)
                coef_shadow[i_cfg_index[2:0]] = i_cfg_data;
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import pnsa_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int ONE_Q24     = 1 << 24;
    localparam int PIX         = 256;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           i_item;
    logic          o_valid;
    t_out          o_result;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [IW-1:0] i_cfg_index;
    logic [CW-1:0] i_cfg_data;
    int            fail_count;
    int            outstanding;
    int            quiet_cycles = 0;
    int            gap_percent;

    projective_nearest_source_address DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    pnsa_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_valid    (o_valid),
        .i_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_fails    (fail_count),
        .o_pending  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Lets the pipeline empty before the coefficients change.
    task automatic drain_pipeline();
        @(negedge i_clk);
        start = 1'b0;
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_word();
        return CW'({$urandom, $urandom});
    endfunction

    task automatic load_coefs(input logic [CW-1:0] rx, ry, ro, cx, cy, co, dx, dy);
        drain_pipeline();
        write_coef(REG_ROW_X, rx);
        write_coef(REG_ROW_Y, ry);
        write_coef(REG_ROW_OFF, ro);
        write_coef(REG_COL_X, cx);
        write_coef(REG_COL_Y, cy);
        write_coef(REG_COL_OFF, co);
        write_coef(REG_DEN_X, dx);
        write_coef(REG_DEN_Y, dy);
        // Indexes past the register file must be ignored.
        write_coef(IW'(NREG + $urandom_range(0, 7)), rand_word());
    endtask

    // One coordinate beat; start stays high into the next beat unless a gap is drawn.
    task automatic send_pixel(input logic [31:0] x, input logic [31:0] y);
        @(negedge i_clk);
        start  = 1'b1;
        i_item = '{world_x: x, world_y: y};
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if ($urandom_range(0, 99) < gap_percent) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    function automatic logic [CW-1:0] rand_scaled(input int span);
        longint v;
        v = longint'($urandom_range(0, 2 * span)) - span;
        return CW'(v * (ONE_Q24 / 64));
    endfunction

    function automatic logic [CW-1:0] rand_den();
        longint v;
        v = longint'($urandom_range(0, 2000)) - 1000;
        return CW'(v * (longint'(1) << 24));
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 1164 * PIX) - 64 * PIX;
        return $urandom;
    endfunction

    initial begin
        logic [CW-1:0] one_q24;
        logic [CW-1:0] max48;
        logic [CW-1:0] min48;
        int            n;
        one_q24     = CW'(ONE_Q24);
        max48       = {1'b0, {(CW-1){1'b1}}};
        min48       = {1'b1, {(CW-1){1'b0}}};
        gap_percent = 11;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Coefficients straight out of reset map everything to the origin.
        send_pixel(32'h7fffffff, 32'h80000000);
        send_pixel(32'h12345678, 32'hedcba987);

        // Row follows y and column follows x, no perspective.
        load_coefs('0, one_q24, '0, one_q24, '0, '0, '0, '0);
        send_pixel(0, 0);
        send_pixel(1023 * PIX, 1023 * PIX);
        send_pixel(1024 * PIX - 129, 1024 * PIX - 128);
        send_pixel(1024 * PIX, 5 * PIX);
        send_pixel(-128, -128);
        send_pixel(-300, 7 * PIX);
        send_pixel(-400, -400);
        send_pixel(32'h7fffffff, 32'h7fffffff);
        send_pixel(32'h80000000, 32'h80000000);
        send_pixel(32'hffffffff, 32'h00000001);

        // A denominator that vanishes at x = 1.0.
        load_coefs('0, one_q24, '0, one_q24, '0, '0, -(CW'(1) << 40), '0);
        send_pixel(PIX, 3 * PIX);
        send_pixel(2 * PIX, 3 * PIX);
        send_pixel(0, 3 * PIX);

        // Register extremes.
        load_coefs(max48, min48, max48, min48, max48, min48, max48, min48);
        send_pixel(32'h7fffffff, 32'h80000000);
        send_pixel(PIX, PIX);
        send_pixel(0, 0);
        load_coefs(min48, max48, min48, max48, min48, max48, min48, max48);
        send_pixel(32'h80000000, 32'h7fffffff);
        send_pixel(-PIX, PIX);

        for (n = 0; n < 700; n++) begin
            if (n % 100 == 0) begin
                if (n % 300 == 200)
                    load_coefs(rand_word(), rand_word(), rand_word(), rand_word(),
                               rand_word(), rand_word(), rand_word(), rand_word());
                else
                    load_coefs(rand_scaled(80), rand_scaled(80),
                               CW'(longint'($urandom_range(0, 200)) * ONE_Q24),
                               rand_scaled(80), rand_scaled(80),
                               CW'(longint'($urandom_range(0, 200)) * ONE_Q24),
                               rand_den(), rand_den());
            end
            gap_percent = (n < 233) ? 11 : (n < 466) ? 85 : 0;
            send_pixel(rand_coord(), rand_coord());
        end
        @(negedge i_clk);
        start = 1'b0;

        while (outstanding != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
